@@ hw/rtl/timestamp_lru_lookup_insert_unit_defines.svh @@
// assertion macros shared by the lookup and insert unit
`ifndef TIMESTAMP_LRU_LOOKUP_INSERT_UNIT_DEFINES_SVH
`define TIMESTAMP_LRU_LOOKUP_INSERT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define TLRU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlru check failed");

// next-cycle implication, checked outside reset
`define TLRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlru check failed");

`else

`define TLRU_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLRU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/tlru_pkg.sv @@
// constants and types of the timestamp lru lookup and insert unit
package tlru_pkg;

  localparam int ENTRIES      = 16;
  localparam int KEY_BITS     = 64;
  localparam int STAMP_BITS   = 32;
  localparam int KEY_TAG_BITS = 64;
  localparam int SIZE_BITS    = 17;
  localparam int SLOT_BITS    = 4;
  localparam int IDX_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS     = $clog2(ENTRIES + 1);

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // one table entry as held in the memory
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [SIZE_BITS-1:0]  size;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

@@ hw/rtl/timestamp_lru_lookup_insert_unit.sv @@
// fully associative table with use-stamp lru replacement: lookup and insert
//
//   channel | direction | handshake          | fields
//   req     | in        | req_valid/req_stall| command, key_tag, object_size
//   rsp     | out       | rsp_valid/rsp_stall| hit, slot, stored_size, replaced_valid
//
// one item at a time; key, size and stamp sit in one memory, valid bits in flops.
// lookup: entries read one per cycle, stops at the first valid match. insert with a
//   free entry skips the scan; insert into a full table reads every stamp for the
//   minimum. a new item is accepted only once the unit is back in idle.
// reset clears the valid bits and the use clock at once; no clearing pass.
// a stalled result waits in the output register and holds the final write-back.
`include "timestamp_lru_lookup_insert_unit_defines.svh"

module timestamp_lru_lookup_insert_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              command,
  input  logic [tlru_pkg::KEY_TAG_BITS-1:0] key_tag,
  input  logic [tlru_pkg::SIZE_BITS-1:0]    object_size,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              hit,
  output logic [tlru_pkg::SLOT_BITS-1:0]    slot,
  output logic [tlru_pkg::SIZE_BITS-1:0]    stored_size,
  output logic                              replaced_valid
);

  import tlru_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [ENTRIES-1:0]    valid;
  logic [STAMP_BITS-1:0] use_clock;
  logic [STAMP_BITS-1:0] stamp_new;

  // item registers
  logic                  cmd;
  logic [KEY_BITS-1:0]   key;
  logic [SIZE_BITS-1:0]  size;
  logic                  found;
  logic [SIZE_BITS-1:0]  hit_size;
  logic [STAMP_BITS-1:0] best;
  logic [IDX_BITS-1:0]   target;
  logic [CNT_BITS-1:0]   iss;
  logic [IDX_BITS-1:0]   rd_idx;
  logic                  rd_pending;

  logic                  accept;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;
  logic [ENTRY_BITS-1:0] ram_rdata;
  logic [ENTRY_BITS-1:0] ram_wdata;
  entry_t                rd_word;
  entry_t                wr_word;
  logic                  key_match;
  logic                  scan_last;
  logic                  scan_stop;
  logic                  scan_issue;
  logic                  out_free;
  logic                  finish_go;
  logic                  ram_we;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign stamp_new = use_clock + STAMP_BITS'(1);

  // lowest-numbered invalid entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!valid[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_BITS'(i);
      end
    end
  end

  // scan control
  assign rd_word    = entry_t'(ram_rdata);
  assign key_match  = rd_pending && valid[rd_idx] && (rd_word.key == key);
  assign scan_last  = rd_pending && (rd_idx == IDX_BITS'(ENTRIES - 1));
  assign scan_stop  = ((cmd == CMD_LOOKUP) && key_match) || scan_last;
  assign scan_issue = (state == S_SCAN) && (iss != CNT_BITS'(ENTRIES)) && !scan_stop;

  // write-back and result hand-off
  assign out_free  = !rsp_valid || !rsp_stall;
  assign finish_go = (state == S_FINISH) && out_free;
  assign ram_we    = finish_go && ((cmd == CMD_INSERT) || found);

  always_comb begin
    wr_word.key   = key;
    wr_word.size  = (cmd == CMD_INSERT) ? size : hit_size;
    wr_word.stamp = stamp_new;
    ram_wdata     = wr_word;
  end

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = ((command == CMD_INSERT) && free_found) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      use_clock  <= '0;
      rsp_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= scan_issue;
      if (ram_we) begin
        valid[target] <= 1'b1;
        use_clock     <= stamp_new;
      end
      if (finish_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= command;
      key      <= key_tag[KEY_BITS-1:0];
      size     <= object_size;
      found    <= 1'b0;
      hit_size <= '0;
      best     <= STAMP_MAX;
      iss      <= '0;
      target   <= ((command == CMD_INSERT) && free_found) ? free_idx : '0;
    end else if (state == S_SCAN) begin
      if (scan_issue) begin
        iss    <= iss + CNT_BITS'(1);
        rd_idx <= iss[IDX_BITS-1:0];
      end
      if (rd_pending) begin
        if (cmd == CMD_LOOKUP) begin
          if (key_match) begin
            found    <= 1'b1;
            target   <= rd_idx;
            hit_size <= rd_word.size;
          end
        end else if (rd_word.stamp < best) begin
          best   <= rd_word.stamp;
          target <= rd_idx;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      hit            <= found;
      slot           <= SLOT_BITS'(target);
      stored_size    <= hit_size;
      replaced_valid <= (cmd == CMD_INSERT) && valid[target];
    end
  end

  // entry memory: key, size and use stamp
  tlru_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target),
    .wdata (ram_wdata),
    .re    (scan_issue),
    .raddr (iss[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // checks
  `TLRU_ASSERT_IMP(a_hit_not_replaced, clk, rst, rsp_valid && hit, !replaced_valid)
  `TLRU_ASSERT_NEXT(a_clock_advances, clk, rst, ram_we, use_clock == $past(stamp_new))
  `TLRU_ASSERT_NEXT(a_clock_holds, clk, rst, !ram_we, $stable(use_clock))
  `TLRU_ASSERT_NEXT(a_write_sets_valid, clk, rst, ram_we, valid[$past(target)])

endmodule

@@ hw/rtl/tlru_ram.sv @@
// generic single-write, single-read memory with registered read data
module tlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
